/* design/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, result codes and controller/datapath interface structs for
// the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int SLOTS_DEF  = 16;
	localparam int FIRE_LIMIT = 16;
	localparam int TIME_W     = 48;
	localparam int IVAL_W     = 32;
	localparam int OWNER_W    = 8;

	localparam logic [2:0] ST_FIRED       = 3'd0;
	localparam logic [2:0] ST_SET_OK      = 3'd1;
	localparam logic [2:0] ST_NO_HANDLER  = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_NOTHING_DUE = 3'd4;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [TIME_W-1:0]  now_ms;
		logic [OWNER_W-1:0] owner_id;
		logic               owner_has_handler;
		logic [IVAL_W-1:0]  interval_ms;
		logic               repeat_mode;
	} req_t;

	typedef struct packed {
		logic [OWNER_W-1:0] fired_owner;
		logic [2:0]         status;
		logic               last;
	} res_t;

	typedef struct packed {
		logic       latch;
		logic       pop_fire;
		logic       calc_req;
		logic       calc_pend;
		logic       insert;
		logic       emit;
		logic [2:0] emit_code;
	} cmd_t;

	typedef struct packed {
		logic is_set;
		logic has_handler;
		logic full;
		logic can_fire;
		logic fire_last;
		logic none_fired;
		logic pend_avail;
		logic cand_vld;
		logic out_free;
	} sts_t;

endpackage

/* design/stq_datapath.sv */
// ----------------------------------------------------------------------------
// stq_datapath
// Sorted slot row, reinsert buffer, deadline adder and result register.
// ----------------------------------------------------------------------------
module stq_datapath #(
	parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stq_pkg::req_t req_data,
	input  stq_pkg::cmd_t cmd,
	input  logic          res_stall,
	output logic          res_valid,
	output stq_pkg::res_t res_data,
	output stq_pkg::sts_t sts
);

	localparam int CW  = $clog2(SLOTS + 1);
	localparam int PW  = $clog2(stq_pkg::FIRE_LIMIT + 1);
	localparam int PIW = $clog2(stq_pkg::FIRE_LIMIT);
	localparam int TW  = stq_pkg::TIME_W;
	localparam int IW  = stq_pkg::IVAL_W;
	localparam int OW  = stq_pkg::OWNER_W;

	stq_pkg::req_t req_q;

	logic [CW-1:0] count_q;
	logic [TW-1:0] dl_q  [SLOTS];
	logic [IW-1:0] iv_q  [SLOTS];
	logic          rp_q  [SLOTS];
	logic [OW-1:0] ow_q  [SLOTS];

	logic [IW-1:0] pend_iv_q [stq_pkg::FIRE_LIMIT];
	logic [OW-1:0] pend_ow_q [stq_pkg::FIRE_LIMIT];
	logic [PW-1:0] pend_wr_q;
	logic [PW-1:0] pend_rd_q;
	logic [PW-1:0] fired_q;

	logic [TW-1:0] cand_dl_q;
	logic [IW-1:0] cand_iv_q;
	logic          cand_rp_q;
	logic [OW-1:0] cand_ow_q;
	logic          cand_vld_q;

	logic          res_vld_q;
	stq_pkg::res_t res_q;

	logic [SLOTS-1:0] le;
	logic             front_due;
	logic             next_due;
	logic [IW-1:0]    calc_iv;
	logic [TW:0]      calc_sum;

	// a cell stays put when it is valid and not later than the candidate
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			le[i] = (i < int'(count_q)) && (dl_q[i] <= cand_dl_q);
		end
	end

	assign front_due = (count_q != '0) && (dl_q[0] <= req_q.now_ms);
	assign next_due  = (count_q > CW'(1)) && (dl_q[1] <= req_q.now_ms);

	assign calc_iv  = cmd.calc_pend ? pend_iv_q[pend_rd_q[PIW-1:0]] : req_q.interval_ms;
	assign calc_sum = {1'b0, req_q.now_ms} + {{(TW + 1 - IW){1'b0}}, calc_iv};

	assign sts.is_set      = (req_q.req_type == stq_pkg::REQ_SET);
	assign sts.has_handler = req_q.owner_has_handler;
	assign sts.full        = (count_q == CW'(SLOTS));
	assign sts.can_fire    = front_due && (fired_q < PW'(stq_pkg::FIRE_LIMIT));
	assign sts.fire_last   = !(next_due && (fired_q < PW'(stq_pkg::FIRE_LIMIT - 1)));
	assign sts.none_fired  = (fired_q == '0);
	assign sts.pend_avail  = (pend_rd_q != pend_wr_q);
	assign sts.cand_vld    = cand_vld_q;
	assign sts.out_free    = !res_vld_q || !res_stall;

	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_data;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pend_wr_q  <= '0;
			pend_rd_q  <= '0;
			fired_q    <= '0;
			cand_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (cmd.latch) begin
				pend_wr_q <= '0;
				pend_rd_q <= '0;
				fired_q   <= '0;
			end
			if (cmd.pop_fire) begin
				count_q <= count_q - CW'(1);
				fired_q <= fired_q + PW'(1);
				if (rp_q[0]) begin
					pend_wr_q <= pend_wr_q + PW'(1);
				end
			end else if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.calc_pend) begin
				pend_rd_q <= pend_rd_q + PW'(1);
			end
			if (cmd.calc_req || cmd.calc_pend) begin
				cand_vld_q <= 1'b1;
			end else if (cmd.insert) begin
				cand_vld_q <= 1'b0;
			end
			if (cmd.emit) begin
				res_vld_q <= 1'b1;
			end else if (!res_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// payload: slot row, reinsert buffer, candidate and result
	always_ff @(posedge clk) begin
		if (cmd.pop_fire) begin
			for (int i = 0; i < SLOTS - 1; i++) begin
				dl_q[i] <= dl_q[i+1];
				iv_q[i] <= iv_q[i+1];
				rp_q[i] <= rp_q[i+1];
				ow_q[i] <= ow_q[i+1];
			end
			if (rp_q[0]) begin
				pend_iv_q[pend_wr_q[PIW-1:0]] <= iv_q[0];
				pend_ow_q[pend_wr_q[PIW-1:0]] <= ow_q[0];
			end
		end else if (cmd.insert) begin
			if (!le[0]) begin
				dl_q[0] <= cand_dl_q;
				iv_q[0] <= cand_iv_q;
				rp_q[0] <= cand_rp_q;
				ow_q[0] <= cand_ow_q;
			end
			for (int i = 1; i < SLOTS; i++) begin
				if (!le[i] && le[i-1]) begin
					dl_q[i] <= cand_dl_q;
					iv_q[i] <= cand_iv_q;
					rp_q[i] <= cand_rp_q;
					ow_q[i] <= cand_ow_q;
				end else if (!le[i]) begin
					dl_q[i] <= dl_q[i-1];
					iv_q[i] <= iv_q[i-1];
					rp_q[i] <= rp_q[i-1];
					ow_q[i] <= ow_q[i-1];
				end
			end
		end

		if (cmd.calc_req || cmd.calc_pend) begin
			cand_dl_q <= calc_sum[TW] ? {TW{1'b1}} : calc_sum[TW-1:0];
			cand_iv_q <= calc_iv;
			cand_rp_q <= cmd.calc_pend ? 1'b1 : req_q.repeat_mode;
			cand_ow_q <= cmd.calc_pend ? pend_ow_q[pend_rd_q[PIW-1:0]] : req_q.owner_id;
		end

		if (cmd.emit) begin
			res_q.status      <= cmd.emit_code;
			res_q.fired_owner <= (cmd.emit_code == stq_pkg::ST_FIRED) ? ow_q[0] : '0;
			res_q.last        <= (cmd.emit_code != stq_pkg::ST_FIRED) || sts.fire_last;
		end
	end

endmodule

/* design/stq_ctrl.sv */
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for set and tick requests: check, fire, reinsert.
// ----------------------------------------------------------------------------
module stq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  stq_pkg::sts_t sts,
	output stq_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SET_CHK = 5'b00010,
		S_SET_INS = 5'b00100,
		S_FIRE    = 5'b01000,
		S_REINS   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_FIRE;
				end
			end
			S_SET_CHK: begin
				if (!sts.has_handler) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = stq_pkg::ST_NO_HANDLER;
						state_d       = S_IDLE;
					end
				end else if (sts.full) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = stq_pkg::ST_FULL;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.calc_req = 1'b1;
					state_d      = S_SET_INS;
				end
			end
			S_SET_INS: begin
				if (sts.out_free) begin
					cmd.insert    = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_code = stq_pkg::ST_SET_OK;
					state_d       = S_IDLE;
				end
			end
			S_FIRE: begin
				if (sts.is_set) begin
					state_d = S_SET_CHK;
				end else if (sts.can_fire) begin
					if (sts.out_free) begin
						cmd.pop_fire  = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_code = stq_pkg::ST_FIRED;
						if (sts.fire_last) begin
							state_d = S_REINS;
						end
					end
				end else if (sts.none_fired) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = stq_pkg::ST_NOTHING_DUE;
						state_d       = S_IDLE;
					end
				end else begin
					state_d = S_REINS;
				end
			end
			S_REINS: begin
				cmd.calc_pend = sts.pend_avail;
				cmd.insert    = sts.cand_vld;
				if (!sts.pend_avail && !sts.cand_vld) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/sorted_timer_queue.sv */
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Up to SLOTS one-shot or periodic timers held in deadline order; set
// requests queue a timer, ticks fire every due timer up to FIRE_LIMIT and
// requeue the periodic ones.
//
//   channel | direction | transfer when          | payload
//   --------+-----------+------------------------+------------------------
//   req     | in        | req_valid && !req_stall | stq_pkg::req_t req_data
//   res     | out       | res_valid && !res_stall | stq_pkg::res_t res_data
//
// An accepted set passes the fire, check and insert states and gives its
// result from the insert state, a rejected one from the check state; the
// sequencer is back in idle, ready for the next request, as the result is
// registered. A tick that fires k timers gives one result per cycle while
// the result port is not stalled, then requeues its r periodic timers one
// per cycle through the single insert port of the sorted slot row, and only
// then takes the next request; a tick with nothing due answers from S_FIRE.
// One request is in work at a time.
// Reset is asynchronous and leaves the queue empty at once.
// A stalled result holds the sequencer until the result register frees.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
	parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  stq_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_stall,
	output stq_pkg::res_t res_data
);

	// command and status between sequencer and datapath
	stq_pkg::cmd_t cmd;
	stq_pkg::sts_t sts;

	// sequencer: accept one request, run its check, fire and requeue steps
	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: sorted slot row with per-cell compare, reinsert buffer,
	// saturating deadline adder and the result register
	stq_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_data  (res_data),
		.sts       (sts)
	);

endmodule

/* design/stq_checker.sv */
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on the sorted timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input stq_pkg::req_t req_data,
	input logic          res_valid,
	input logic          res_stall,
	input stq_pkg::res_t res_data
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	// one request in work at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in work");

	// only a fired result carries an owner
	a_owner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status != stq_pkg::ST_FIRED) |-> res_data.fired_owner == '0)
		else $error("owner on a non-fire result");

	// every non-fire result closes its request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status != stq_pkg::ST_FIRED) |-> res_data.last)
		else $error("non-fire result without last");

	// no status code beyond the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.status <= stq_pkg::ST_NOTHING_DUE)
		else $error("undefined status code");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_timer_queue. A directed table covers the
// empty queue, rejections, saturation, ties, zero intervals and a full queue.
// A random stream of set and tick requests follows, modelled on a running
// clock. Every result is checked against its table row or the timer list.
// ----------------------------------------------------------------------------
module testbench;
	import stq_pkg::*;

	localparam int SLOTS        = SLOTS_DEF;
	localparam int RANDOM_ITEMS = 250;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS  = 10;
	localparam int HOLD_FROM    = 300;
	localparam int HOLD_TO      = 500;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [IVAL_W-1:0] IVAL_MAX = '1;

	// One row of the directed table: the request, and where the answer is
	// obvious, the single result it must give.
	typedef struct packed {
		req_t req;
		logic typed;
		res_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;

	sorted_timer_queue #(.SLOTS(SLOTS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// ------------------------------------------------------------------
	// Timer list: our own copy of the queue, front entry earliest.
	// ------------------------------------------------------------------
	logic [TIME_W-1:0]  tq_deadline [SLOTS];
	logic [IVAL_W-1:0]  tq_interval [SLOTS];
	logic               tq_periodic [SLOTS];
	logic [OWNER_W-1:0] tq_owner    [SLOTS];
	int                 tq_count;

	res_t step_results[$];   // results of the request just transferred
	res_t owed_results[$];   // results the block still owes, oldest first

	row_t              stim_table[$];
	logic [TIME_W-1:0] sim_now;
	int                burst_left;
	int                mismatches;
	int                cycle_count;
	bit                stim_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic req_t make_req(input logic kind, input logic [TIME_W-1:0] now,
			input logic [OWNER_W-1:0] ow, input logic hnd,
			input logic [IVAL_W-1:0] iv, input logic rp);
		req_t r;
		r.req_type          = kind;
		r.now_ms            = now;
		r.owner_id          = ow;
		r.owner_has_handler = hnd;
		r.interval_ms       = iv;
		r.repeat_mode       = rp;
		return r;
	endfunction

	function automatic res_t make_res(input logic [OWNER_W-1:0] ow, input logic [2:0] st,
			input logic lst);
		res_t r;
		r.fired_owner = ow;
		r.status      = st;
		r.last        = lst;
		return r;
	endfunction

	// List helpers: append at the tail, take from the head.
	task automatic step_add(input res_t x);
		step_results.insert(step_results.size(), x);
	endtask

	task automatic owed_add(input res_t x);
		owed_results.insert(owed_results.size(), x);
	endtask

	task automatic row_add(input row_t x);
		stim_table.insert(stim_table.size(), x);
	endtask

	function automatic res_t owed_take();
		res_t x;
		x = owed_results[0];
		owed_results.delete(0);
		return x;
	endfunction

	// Deadline of a timer: now plus interval, clamped to the largest time.
	function automatic logic [TIME_W-1:0] due_time(input logic [TIME_W-1:0] now,
			input logic [IVAL_W-1:0] iv);
		logic [TIME_W:0] sum;
		sum = {1'b0, now} + {{(TIME_W + 1 - IVAL_W){1'b0}}, iv};
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	// Insert behind every entry whose deadline is at or before d, so that
	// equal deadlines keep their arrival order.
	task automatic tq_insert(input logic [TIME_W-1:0] d, input logic [IVAL_W-1:0] iv,
			input logic rp, input logic [OWNER_W-1:0] ow);
		int pos;
		if (tq_count >= SLOTS)
			return;
		pos = tq_count;
		while (pos > 0 && tq_deadline[pos-1] > d) begin
			tq_deadline[pos] = tq_deadline[pos-1];
			tq_interval[pos] = tq_interval[pos-1];
			tq_periodic[pos] = tq_periodic[pos-1];
			tq_owner[pos]    = tq_owner[pos-1];
			pos--;
		end
		tq_deadline[pos] = d;
		tq_interval[pos] = iv;
		tq_periodic[pos] = rp;
		tq_owner[pos]    = ow;
		tq_count++;
	endtask

	// Apply one request to the timer list and leave its results in
	// step_results.
	task automatic timer_step(input req_t r);
		logic [IVAL_W-1:0]  p_iv [FIRE_LIMIT];
		logic               p_rp [FIRE_LIMIT];
		logic [OWNER_W-1:0] p_ow [FIRE_LIMIT];
		int                 k;
		step_results.delete();
		if (r.req_type == REQ_SET) begin
			// Handler check comes before the full check.
			if (!r.owner_has_handler) begin
				step_add(make_res('0, ST_NO_HANDLER, 1'b1));
			end else if (tq_count >= SLOTS) begin
				step_add(make_res('0, ST_FULL, 1'b1));
			end else begin
				tq_insert(due_time(r.now_ms, r.interval_ms), r.interval_ms,
					r.repeat_mode, r.owner_id);
				step_add(make_res('0, ST_SET_OK, 1'b1));
			end
		end else begin
			// Pop expired timers from the front, at most FIRE_LIMIT of them.
			k = 0;
			while (k < tq_count && k < FIRE_LIMIT && tq_deadline[k] <= r.now_ms) begin
				p_iv[k] = tq_interval[k];
				p_rp[k] = tq_periodic[k];
				p_ow[k] = tq_owner[k];
				k++;
			end
			if (k == 0) begin
				step_add(make_res('0, ST_NOTHING_DUE, 1'b1));
			end else begin
				for (int i = k; i < tq_count; i++) begin
					tq_deadline[i-k] = tq_deadline[i];
					tq_interval[i-k] = tq_interval[i];
					tq_periodic[i-k] = tq_periodic[i];
					tq_owner[i-k]    = tq_owner[i];
				end
				tq_count -= k;
				for (int i = 0; i < k; i++)
					step_add(make_res(p_ow[i], ST_FIRED, i == k - 1));
				// Requeue periodic timers only after the whole batch has fired,
				// so none of them fires twice in one tick.
				for (int i = 0; i < k; i++)
					if (p_rp[i])
						tq_insert(due_time(r.now_ms, p_iv[i]), p_iv[i], 1'b1, p_ow[i]);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking: compare each transfer with the oldest owed result.
	// ------------------------------------------------------------------
	task automatic check_result(input res_t got);
		res_t want;
		if (owed_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0d] unexpected result: owner %0d status %0d last %0d",
					cycle_count, got.fired_owner, got.status, got.last);
			return;
		end
		want = owed_take();
		if (got.fired_owner !== want.fired_owner || got.status !== want.status ||
				got.last !== want.last) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0d] result mismatch: expected owner %0d status %0d last %0d,",
					cycle_count, want.fired_owner, want.status, want.last,
					" got owner %0d status %0d last %0d",
					got.fired_owner, got.status, got.last);
		end
	endtask

	// Sample on the rising edge; our stall was set at the falling edge.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			check_result(res_data);
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Request side: offer one request, hold it until its transfer.
	// ------------------------------------------------------------------
	task automatic send_request(input req_t r, input logic typed, input res_t want);
		int gap;
		// Work in bursts; open a gap only when a burst runs out.
		gap = 0;
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
		end
		burst_left--;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
		timer_step(r);
		if (typed)
			owed_add(want);
		else
			foreach (step_results[i])
				owed_add(step_results[i]);
		@(negedge clk);
	endtask

	// Draw one random request. Time mostly runs forward in small steps with
	// short intervals, so timers really expire; now and then a far time or
	// a full-width interval comes in, and every few dozen items a flood of
	// sets drives the queue into the full case.
	task automatic draw_request(input int idx, output req_t r);
		int pick;
		int n_periodic;
		r          = '0;
		pick       = $urandom_range(0, 99);
		n_periodic = 0;
		for (int i = 0; i < tq_count; i++)
			if (tq_periodic[i])
				n_periodic++;
		r.req_type          = ((idx % 50) < 12 || $urandom_range(0, 1) == 1) ? REQ_SET : REQ_TICK;
		r.owner_id          = OWNER_W'($urandom());
		r.owner_has_handler = ($urandom_range(0, 9) != 0);
		r.interval_ms       = (pick < 6) ? IVAL_W'($urandom()) : IVAL_W'($urandom_range(0, 40));
		r.repeat_mode       = ($urandom_range(0, 3) == 0);
		if (r.req_type == REQ_TICK) begin
			if (pick < 4) begin
				r.now_ms = TIME_MAX;
			end else if (pick < 8) begin
				r.now_ms = {16'($urandom()), 32'($urandom())};
			end else begin
				sim_now  = sim_now + TIME_W'($urandom_range(0, 15));
				r.now_ms = sim_now;
			end
		end else begin
			r.now_ms = (pick >= 94) ? {16'($urandom()), 32'($urandom())} : sim_now;
			// Periodic timers never leave; cap them so the queue keeps room.
			if (n_periodic >= 5)
				r.repeat_mode = 1'b0;
		end
	endtask

	initial begin
		req_t r;
		req_valid  = 1'b0;
		req_data   = '0;
		burst_left = 0;
		sim_now    = '0;
		stim_done  = 1'b0;

		// Empty queue, then a set with no handler.
		row_add(row_t'{make_req(REQ_TICK, '0, '0, 1'b1, '0, 1'b0), 1'b1,
			make_res('0, ST_NOTHING_DUE, 1'b1)});
		row_add(row_t'{make_req(REQ_SET, '0, 8'd9, 1'b0, 32'd5, 1'b0), 1'b1,
			make_res('0, ST_NO_HANDLER, 1'b1)});
		// Owner zero with zero interval; then the largest time and interval,
		// which must saturate the deadline.
		row_add(row_t'{make_req(REQ_SET, '0, 8'd0, 1'b1, '0, 1'b0), 1'b1,
			make_res('0, ST_SET_OK, 1'b1)});
		row_add(row_t'{make_req(REQ_SET, TIME_MAX, 8'd255, 1'b1, IVAL_MAX, 1'b1),
			1'b1, make_res('0, ST_SET_OK, 1'b1)});
		// Two timers with the same deadline: they must fire in arrival order.
		row_add(row_t'{make_req(REQ_SET, '0, 8'd5, 1'b1, 32'd10, 1'b1), 1'b1,
			make_res('0, ST_SET_OK, 1'b1)});
		row_add(row_t'{make_req(REQ_SET, '0, 8'd6, 1'b1, 32'd10, 1'b0), 1'b1,
			make_res('0, ST_SET_OK, 1'b1)});
		// Periodic with zero interval: fires once per tick, never loops.
		row_add(row_t'{make_req(REQ_SET, 48'd5, 8'd7, 1'b1, '0, 1'b1), 1'b1,
			make_res('0, ST_SET_OK, 1'b1)});
		row_add(row_t'{make_req(REQ_TICK, '0, '0, 1'b0, '0, 1'b0), 1'b0, '0});
		row_add(row_t'{make_req(REQ_TICK, 48'd10, '0, 1'b0, '0, 1'b0), 1'b0, '0});
		// Fill the remaining slots, then hit the full queue with and without
		// a handler, then fire the whole queue in one tick.
		for (int i = 0; i < 13; i++)
			row_add(row_t'{make_req(REQ_SET, TIME_W'(20 + i), OWNER_W'(8'h80 + i),
				1'b1, IVAL_W'(3 * i), i == 0), 1'b1, make_res('0, ST_SET_OK, 1'b1)});
		row_add(row_t'{make_req(REQ_SET, 48'd40, 8'd1, 1'b1, 32'd1, 1'b0), 1'b1,
			make_res('0, ST_FULL, 1'b1)});
		row_add(row_t'{make_req(REQ_SET, 48'd40, 8'd2, 1'b0, 32'd1, 1'b0), 1'b1,
			make_res('0, ST_NO_HANDLER, 1'b1)});
		row_add(row_t'{make_req(REQ_TICK, TIME_MAX, '0, 1'b1, IVAL_MAX, 1'b1),
			1'b0, '0});

		@(posedge arst_n);
		@(negedge clk);
		foreach (stim_table[i])
			send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].res);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			draw_request(i, r);
			send_request(r, 1'b0, '0);
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// ------------------------------------------------------------------
	// Result side: stall on a changing pattern, plus one long hold-off so
	// that the block fills up and pushes back on its request port.
	// ------------------------------------------------------------------
	initial begin
		int n;
		int mode;
		res_stall = 1'b0;
		n         = 0;
		mode      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n++;
			if (n % 64 == 0)
				mode = $urandom_range(0, 3);
			if (n >= HOLD_FROM && n < HOLD_TO) begin
				res_stall <= 1'b1;
			end else begin
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					2: res_stall <= ($urandom_range(0, 9) < 7);
					default: res_stall <= (n % 2 == 1);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Reset, then wait for the stimulus to finish and every result to
	// arrive; allow a few more cycles to catch stray transfers.
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		tq_count    = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/stq_pkg.sv
design/stq_datapath.sv
design/stq_ctrl.sv
design/sorted_timer_queue.sv
design/stq_checker.sv
tb/testbench.sv
